// ----- src/magma_pkg.sv -----
// ----------------------------------------------------------------------------
// magma_pkg
// Shared constants, types and round functions of the Magma block cipher.
// ----------------------------------------------------------------------------
package magma_pkg;

   localparam int HALF_W     = 32;
   localparam int BLOCK_W    = 2 * HALF_W;
   localparam int ROUNDS     = 32;
   localparam int KEY_WORDS  = 8;
   localparam int KEY_SEL_W  = $clog2(KEY_WORDS);
   localparam int STAGE_W    = $clog2(ROUNDS);
   localparam int CSR_IDX_W  = 4;
   localparam int ROTATE     = 11;
   localparam int FWD_ROUNDS = 24;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [HALF_W-1:0] word_type;
   typedef logic [KEY_WORDS-1:0][HALF_W-1:0] key_set_type;

   typedef struct packed {
      logic     valid;
      logic     op;
      word_type left;
      word_type right;
   } stage_type;

   // row 0 serves the most significant nibble
   localparam logic [3:0] SBOX [KEY_WORDS][16] = '{
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1}
   };

   function automatic word_type substitute(input word_type x);
      word_type y;
      y = '0;
      for (int n = 0; n < KEY_WORDS; n++) begin
         y[HALF_W-4-4*n +: 4] = SBOX[n][x[HALF_W-4-4*n +: 4]];
      end
      return y;
   endfunction

   function automatic word_type round_fn(input word_type k, input word_type a);
      word_type v;
      v = substitute(a + k);
      return {v[HALF_W-ROTATE-1:0], v[HALF_W-1:HALF_W-ROTATE]};
   endfunction

   // key word used at pipeline stage s; encrypt: forward K1..K8 x3 then K8..K1; decrypt: K1..K8 then K8..K1 x3
   function automatic logic [KEY_SEL_W-1:0] key_sel(input logic [STAGE_W-1:0] s,
                                                    input logic op);
      logic fwd;
      if (op == OP_DECRYPT) begin
         fwd = (int'(s) < ROUNDS - FWD_ROUNDS);
      end else begin
         fwd = (int'(s) < FWD_ROUNDS);
      end
      return fwd ? s[KEY_SEL_W-1:0] : ~s[KEY_SEL_W-1:0];
   endfunction

endpackage

// ----- src/magma_key_regs.sv -----
// ----------------------------------------------------------------------------
// magma_key_regs
// Key word register file, written through the CSR channel.
// ----------------------------------------------------------------------------
module magma_key_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [magma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [magma_pkg::HALF_W-1:0]       csr_data,
   output magma_pkg::key_set_type             keys
);

   magma_pkg::key_set_type keys_ff, keys_in;
   logic                   hit;

   assign csr_ready = 1'b1;
   assign hit = csr_valid && (int'(csr_index) < magma_pkg::KEY_WORDS);

   always_comb begin
      keys_in = keys_ff;
      if (hit) begin
         keys_in[csr_index[magma_pkg::KEY_SEL_W-1:0]] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

`ifndef SYNTHESIS
   a_key_write: assert property (@(posedge clock) disable iff (reset)
      hit |=> keys_ff[$past(csr_index[magma_pkg::KEY_SEL_W-1:0])] == $past(csr_data))
      else $error("key word not updated by CSR beat");
   a_key_hold: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(keys_ff))
      else $error("key words changed without CSR beat");
   a_index_drop: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && !hit) |=> $stable(keys_ff))
      else $error("key words changed by out-of-range CSR beat");
`endif

endmodule

// ----- src/magma_round.sv -----
// ----------------------------------------------------------------------------
// magma_round
// One Feistel round with its stage register.
// ----------------------------------------------------------------------------
module magma_round (
   input  logic                  clock,
   input  logic                  reset,
   input  magma_pkg::word_type   key_enc,
   input  magma_pkg::word_type   key_dec,
   input  magma_pkg::stage_type  stage_i,
   output magma_pkg::stage_type  stage_o
);

   magma_pkg::stage_type stage_ff, stage_in;
   magma_pkg::word_type  key;

   assign key = (stage_i.op == magma_pkg::OP_DECRYPT) ? key_dec : key_enc;

   always_comb begin
      stage_in.valid = stage_i.valid;
      stage_in.op    = stage_i.op;
      stage_in.left  = stage_i.right;
      stage_in.right = stage_i.left ^ magma_pkg::round_fn(key, stage_i.right);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.op    <= stage_in.op;
      stage_ff.left  <= stage_in.left;
      stage_ff.right <= stage_in.right;
   end

   assign stage_o = stage_ff;

endmodule

// ----- src/magma_block_cipher.sv -----
// ----------------------------------------------------------------------------
// magma_block_cipher
// Magma (GOST 64-bit) block cipher, 32 rounds unrolled into a pipeline.
// ----------------------------------------------------------------------------
// A block is taken every cycle (busy stays low) and its result appears on
// rsp_block_out with rsp_valid once it has passed every round stage register;
// results leave in the order blocks came in and cannot be held off.
// Key words are written through the csr_ channel (index 0..7, higher indexes
// ignored) and must only change while no block is in the pipeline.
module magma_block_cipher (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [magma_pkg::BLOCK_W-1:0]      req_block_in,
   output logic                               rsp_valid,
   output logic [magma_pkg::BLOCK_W-1:0]      rsp_block_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [magma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [magma_pkg::HALF_W-1:0]       csr_data
);

   magma_pkg::key_set_type keys;
   magma_pkg::stage_type   pipe [magma_pkg::ROUNDS+1];
   magma_pkg::stage_type   last;

   assign busy = 1'b0;

   magma_key_regs u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   always_comb begin
      pipe[0].valid = start && !busy;
      pipe[0].op    = req_operation;
      pipe[0].left  = req_block_in[magma_pkg::BLOCK_W-1:magma_pkg::HALF_W];
      pipe[0].right = req_block_in[magma_pkg::HALF_W-1:0];
   end

   for (genvar g = 0; g < magma_pkg::ROUNDS; g++) begin : g_round
      magma_round u_round (
         .clock   (clock),
         .reset   (reset),
         .key_enc (keys[magma_pkg::key_sel(magma_pkg::STAGE_W'(g),
                                           magma_pkg::OP_ENCRYPT)]),
         .key_dec (keys[magma_pkg::key_sel(magma_pkg::STAGE_W'(g),
                                           magma_pkg::OP_DECRYPT)]),
         .stage_i (pipe[g]),
         .stage_o (pipe[g+1])
      );
   end

   assign last = pipe[magma_pkg::ROUNDS];

   // every stage swaps; the final round must not, so swap back here
   assign rsp_valid     = last.valid;
   assign rsp_block_out = {last.right, last.left};

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, magma_pkg::ROUNDS))
      else $error("result beat without matching request");
   a_op_follow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(reset, magma_pkg::ROUNDS) == 1'b0)
         |-> last.op == $past(req_operation, magma_pkg::ROUNDS))
      else $error("operation bit lost in pipeline");
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      start |=> pipe[1].valid)
      else $error("accepted beat did not enter first round");
`endif

endmodule
